// ----- rtl/core/sema_pkg.sv -----
// sema_pkg: widths, payload structs and constants of the signal error metric accumulator
`timescale 1ns / 1ps
`default_nettype none

package sema_pkg;

  // sample and capacity sizing
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_LOG2  = 20;

  // derived field widths
  localparam int CNT_W      = COUNT_LOG2 + 1;
  localparam int SUM_W      = SAMPLE_BITS + COUNT_LOG2;
  localparam int SQO_W      = 2 * SAMPLE_BITS - 1 + COUNT_LOG2;
  localparam int SQD_W      = 2 * SAMPLE_BITS + COUNT_LOG2;
  localparam int DIFF_W     = SAMPLE_BITS + 1;
  localparam int SQO_PROD_W = 2 * SAMPLE_BITS - 1;
  localparam int SQD_PROD_W = 2 * SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
  localparam logic [CNT_W-1:0] CAPACITY = {1'b1, {COUNT_LOG2{1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] original_sample;
    logic signed [SAMPLE_BITS-1:0] reconstructed_sample;
    logic                          last_pair;
  } in_item_t;

  typedef struct packed {
    logic        [CNT_W-1:0]       pair_count;
    logic signed [SUM_W-1:0]       sum_original;
    logic        [SQO_W-1:0]       sumsq_original;
    logic        [SQD_W-1:0]       sumsq_difference;
    logic        [SAMPLE_BITS-1:0] peak_abs_difference;
    logic signed [SAMPLE_BITS-1:0] original_minimum;
    logic signed [SAMPLE_BITS-1:0] original_maximum;
    logic signed [SAMPLE_BITS-1:0] joint_minimum;
    logic signed [SAMPLE_BITS-1:0] joint_maximum;
    logic                          count_overflow;
  } out_item_t;

  // per-pair terms handed from the product stage to the accumulator
  typedef struct packed {
    sample_t                 original;
    sample_t                 pair_min;
    sample_t                 pair_max;
    logic [SAMPLE_BITS-1:0]  abs_diff;
    logic [SQO_PROD_W-1:0]   sq_original;
    logic [SQD_PROD_W-1:0]   sq_difference;
    logic                    last;
  } terms_t;

endpackage

`default_nettype wire

// ----- rtl/core/signal_error_metric_accumulator.sv -----
// signal_error_metric_accumulator: top level of the error metric accumulator
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake               payload
// in       sink       in_valid_i / in_stall_o  in_item_i  (sample pair, last flag)
// out      source     out_valid_o / out_stall_i out_item_o (one result per measurement)
//
// one sample pair per cycle sustained unless in_stall_o is high; a pair moves
// through the input register, the product stage (two squares, difference, pair
// min/max) and the accumulators; the result is registered when a last pair fires
// reset clears the accumulators to their starting values at once, no sweep
// the result register holds a finished result while out is stalled; input
// stalls only when a further last pair waits at the accumulators meanwhile
// and the input register is occupied

module signal_error_metric_accumulator (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sema_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sema_pkg::out_item_t      out_item_o
);
  import sema_pkg::*;

  // product stage to accumulator
  logic   terms_valid;
  terms_t terms;
  logic   hold;

  sema_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .hold_i        (hold),
    .terms_valid_o (terms_valid),
    .terms_o       (terms)
  );

  // accumulators update on every pair leaving the product stage
  sema_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .terms_valid_i (terms_valid),
    .terms_i       (terms),
    .hold_o        (hold),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // overflow is only possible with the count pinned at capacity
  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.count_overflow) |-> (out_item_o.pair_count == CAPACITY))
    else $error("overflow flagged below capacity");

  // every result covers at least one pair
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pair_count != '0))
    else $error("result with no accumulated pair");

  // joint range always encloses the original range
  a_joint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.joint_minimum <= out_item_o.original_minimum) &&
                     (out_item_o.original_maximum <= out_item_o.joint_maximum)))
    else $error("joint range does not enclose original range");

  // hold on a last pair keeps the pending result in place
  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> out_valid_o)
    else $error("pending result dropped while a last pair waited");

endmodule

`default_nettype wire

// ----- rtl/core/sema_front.sv -----
// sema_front: input register and per-pair product stage
`timescale 1ns / 1ps
`default_nettype none

module sema_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sema_pkg::in_item_t in_item_i,
  input  wire logic              hold_i,
  output logic                   terms_valid_o,
  output sema_pkg::terms_t       terms_o
);
  import sema_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_q;
  logic     s2_valid_q, s2_valid_d;
  terms_t   s2_q, s2_d;
  logic     s1_hold;

  logic signed [DIFF_W-1:0]       diff;
  logic signed [DIFF_W-1:0]       diff_abs;
  logic signed [2*SAMPLE_BITS-1:0] sqo_full;
  logic signed [2*DIFF_W-1:0]      sqd_full;

  // first stage can only hold when the product stage is held and full
  assign s1_hold    = s1_valid_q & hold_i;
  assign in_stall_o = s1_hold;

  assign s1_valid_d = s1_hold ? s1_valid_q : in_valid_i;
  assign s2_valid_d = hold_i ? s2_valid_q : s1_valid_q;

  assign diff = $signed({s1_q.original_sample[SAMPLE_BITS-1], s1_q.original_sample})
              - $signed({s1_q.reconstructed_sample[SAMPLE_BITS-1],
                         s1_q.reconstructed_sample});
  assign diff_abs = diff[DIFF_W-1] ? -diff : diff;
  assign sqo_full = (2*SAMPLE_BITS)'(s1_q.original_sample)
                  * (2*SAMPLE_BITS)'(s1_q.original_sample);
  assign sqd_full = (2*DIFF_W)'(diff) * (2*DIFF_W)'(diff);

  always_comb begin
    s2_d.original      = s1_q.original_sample;
    s2_d.pair_min      = (s1_q.original_sample < s1_q.reconstructed_sample) ?
                         s1_q.original_sample : s1_q.reconstructed_sample;
    s2_d.pair_max      = (s1_q.original_sample > s1_q.reconstructed_sample) ?
                         s1_q.original_sample : s1_q.reconstructed_sample;
    s2_d.abs_diff      = diff_abs[SAMPLE_BITS-1:0];
    s2_d.sq_original   = sqo_full[SQO_PROD_W-1:0];
    s2_d.sq_difference = sqd_full[SQD_PROD_W-1:0];
    s2_d.last          = s1_q.last_pair;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !s1_hold) begin
      s1_q <= in_item_i;
    end
    if (s1_valid_q && !hold_i) begin
      s2_q <= s2_d;
    end
  end

  assign terms_valid_o = s2_valid_q;
  assign terms_o       = s2_q;

endmodule

`default_nettype wire

// ----- rtl/core/sema_accum.sv -----
// sema_accum: running accumulators, min/max trackers and result register
`timescale 1ns / 1ps
`default_nettype none

module sema_accum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             terms_valid_i,
  input  wire sema_pkg::terms_t terms_i,
  output logic                  hold_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sema_pkg::out_item_t   out_item_o
);
  import sema_pkg::*;

  logic                    ovf_q, ovf_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQO_W-1:0]        sqo_q, sqo_d;
  logic [SQD_W-1:0]        sqd_q, sqd_d;
  logic [SAMPLE_BITS-1:0]  peak_q, peak_d;
  sample_t                 omin_q, omin_d;
  sample_t                 omax_q, omax_d;
  sample_t                 jmin_q, jmin_d;
  sample_t                 jmax_q, jmax_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      fire, full;

  // a last pair waits here while the previous result is still stalled
  assign hold_o = terms_valid_i & terms_i.last & out_valid_q & out_stall_i;
  assign fire   = terms_valid_i & ~hold_o;
  assign full   = (count_q == CAPACITY);

  always_comb begin
    ovf_d   = ovf_q;
    count_d = count_q;
    sum_d   = sum_q;
    sqo_d   = sqo_q;
    sqd_d   = sqd_q;
    peak_d  = peak_q;
    omin_d  = omin_q;
    omax_d  = omax_q;
    jmin_d  = jmin_q;
    jmax_d  = jmax_q;
    if (full) begin
      ovf_d = 1'b1;
    end else begin
      count_d = count_q + CNT_W'(1);
      sum_d   = sum_q + $signed({{COUNT_LOG2{terms_i.original[SAMPLE_BITS-1]}},
                                 terms_i.original});
      sqo_d   = sqo_q + {{(SQO_W-SQO_PROD_W){1'b0}}, terms_i.sq_original};
      sqd_d   = sqd_q + {{(SQD_W-SQD_PROD_W){1'b0}}, terms_i.sq_difference};
      if (terms_i.abs_diff > peak_q) begin
        peak_d = terms_i.abs_diff;
      end
      if (terms_i.original < omin_q) begin
        omin_d = terms_i.original;
      end
      if (terms_i.original > omax_q) begin
        omax_d = terms_i.original;
      end
      if (terms_i.pair_min < jmin_q) begin
        jmin_d = terms_i.pair_min;
      end
      if (terms_i.pair_max > jmax_q) begin
        jmax_d = terms_i.pair_max;
      end
    end

    out_d.pair_count          = count_d;
    out_d.sum_original        = sum_d;
    out_d.sumsq_original      = sqo_d;
    out_d.sumsq_difference    = sqd_d;
    out_d.peak_abs_difference = peak_d;
    out_d.original_minimum    = omin_d;
    out_d.original_maximum    = omax_d;
    out_d.joint_minimum       = jmin_d;
    out_d.joint_maximum       = jmax_d;
    out_d.count_overflow      = ovf_d;

    priority if (fire && terms_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      sqo_q       <= '0;
      sqd_q       <= '0;
      peak_q      <= '0;
      omin_q      <= SAMPLE_MAX;
      omax_q      <= SAMPLE_MIN;
      jmin_q      <= SAMPLE_MAX;
      jmax_q      <= SAMPLE_MIN;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        if (terms_i.last) begin
          // measurement closed: back to the starting state
          ovf_q   <= 1'b0;
          count_q <= '0;
          sum_q   <= '0;
          sqo_q   <= '0;
          sqd_q   <= '0;
          peak_q  <= '0;
          omin_q  <= SAMPLE_MAX;
          omax_q  <= SAMPLE_MIN;
          jmin_q  <= SAMPLE_MAX;
          jmax_q  <= SAMPLE_MIN;
        end else begin
          ovf_q   <= ovf_d;
          count_q <= count_d;
          sum_q   <= sum_d;
          sqo_q   <= sqo_d;
          sqd_q   <= sqd_d;
          peak_q  <= peak_d;
          omin_q  <= omin_d;
          omax_q  <= omax_d;
          jmin_q  <= jmin_d;
          jmax_q  <= jmax_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && terms_i.last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking regression of the signal error metric accumulator
`timescale 1ns / 1ps

module testbench;
  import sema_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned IDLE_PERCENT = 37;
  localparam int unsigned PRINT_LIMIT  = 100;

  logic      clk          = 1'b0;
  logic      rst_n        = 1'b0;
  logic      pair_valid   = 1'b0;
  logic      pair_stall;
  in_item_t  pair_item    = '0;
  logic      metric_valid;
  logic      metric_stall = 1'b0;
  out_item_t metric_item;

  bit          traffic_gaps = 1'b1;
  int          stall_hold   = 0;
  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;

  // running metrics of the measurement in progress
  logic        [CNT_W-1:0]       run_count;
  logic signed [SUM_W-1:0]       run_sum;
  logic        [SQO_W-1:0]       run_sumsq_orig;
  logic        [SQD_W-1:0]       run_sumsq_diff;
  logic        [SAMPLE_BITS-1:0] run_peak;
  sample_t                       run_orig_min;
  sample_t                       run_orig_max;
  sample_t                       run_joint_min;
  sample_t                       run_joint_max;
  logic                          run_overflow;

  out_item_t expected_metrics[$];

  always #10 clk = ~clk;

  signal_error_metric_accumulator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (pair_valid),
    .in_stall_o (pair_stall),
    .in_item_i  (pair_item),
    .out_valid_o(metric_valid),
    .out_stall_i(metric_stall),
    .out_item_o (metric_item)
  );

  function automatic void clear_metrics();
    run_count      = '0;
    run_sum        = '0;
    run_sumsq_orig = '0;
    run_sumsq_diff = '0;
    run_peak       = '0;
    run_orig_min   = SAMPLE_MAX;
    run_orig_max   = SAMPLE_MIN;
    run_joint_min  = SAMPLE_MAX;
    run_joint_max  = SAMPLE_MIN;
    run_overflow   = 1'b0;
  endfunction

  initial clear_metrics();

  // fold one transferred pair into the running metrics, queue a result on last
  function automatic void accumulate_pair(in_item_t p);
    sample_t                       a;
    sample_t                       b;
    logic signed [SAMPLE_BITS:0]   diff;
    logic        [SAMPLE_BITS-1:0] mag;
    logic signed [SUM_W-1:0]       a_ext;
    logic        [SQO_W-1:0]       sq_a;
    logic        [SQD_W-1:0]       sq_d;
    out_item_t                     done;
    a = p.original_sample;
    b = p.reconstructed_sample;
    if (run_count == CAPACITY) begin
      // full: pair is dropped, only the flag moves
      run_overflow = 1'b1;
    end else begin
      diff  = a - b;
      mag   = (diff < 0) ? -diff : diff;
      a_ext = a;
      sq_a  = a * a;
      sq_d  = mag * mag;
      run_count      = run_count + 1'b1;
      run_sum        = run_sum + a_ext;
      run_sumsq_orig = run_sumsq_orig + sq_a;
      run_sumsq_diff = run_sumsq_diff + sq_d;
      if (mag > run_peak) run_peak = mag;
      if (a < run_orig_min) run_orig_min = a;
      if (a > run_orig_max) run_orig_max = a;
      if (a < run_joint_min) run_joint_min = a;
      if (b < run_joint_min) run_joint_min = b;
      if (a > run_joint_max) run_joint_max = a;
      if (b > run_joint_max) run_joint_max = b;
    end
    if (p.last_pair) begin
      done.pair_count          = run_count;
      done.sum_original        = run_sum;
      done.sumsq_original      = run_sumsq_orig;
      done.sumsq_difference    = run_sumsq_diff;
      done.peak_abs_difference = run_peak;
      done.original_minimum    = run_orig_min;
      done.original_maximum    = run_orig_max;
      done.joint_minimum       = run_joint_min;
      done.joint_maximum       = run_joint_max;
      done.count_overflow      = run_overflow;
      expected_metrics.push_back(done);
      clear_metrics();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  task automatic compare_metrics(out_item_t got, out_item_t want);
    if (got.pair_count !== want.pair_count)
      report_mismatch("pair_count", got.pair_count, want.pair_count);
    if (got.sum_original !== want.sum_original)
      report_mismatch("sum_original", got.sum_original, want.sum_original);
    if (got.sumsq_original !== want.sumsq_original)
      report_mismatch("sumsq_original", got.sumsq_original, want.sumsq_original);
    if (got.sumsq_difference !== want.sumsq_difference)
      report_mismatch("sumsq_difference", got.sumsq_difference, want.sumsq_difference);
    if (got.peak_abs_difference !== want.peak_abs_difference)
      report_mismatch("peak_abs_difference", got.peak_abs_difference,
                      want.peak_abs_difference);
    if (got.original_minimum !== want.original_minimum)
      report_mismatch("original_minimum", got.original_minimum, want.original_minimum);
    if (got.original_maximum !== want.original_maximum)
      report_mismatch("original_maximum", got.original_maximum, want.original_maximum);
    if (got.joint_minimum !== want.joint_minimum)
      report_mismatch("joint_minimum", got.joint_minimum, want.joint_minimum);
    if (got.joint_maximum !== want.joint_maximum)
      report_mismatch("joint_maximum", got.joint_maximum, want.joint_maximum);
    if (got.count_overflow !== want.count_overflow)
      report_mismatch("count_overflow", got.count_overflow, want.count_overflow);
  endtask

  // result side: check every transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && metric_valid && !metric_stall) begin
      if (expected_metrics.size() == 0) begin
        report_mismatch("result with nothing expected", '0, '0);
      end else begin
        want = expected_metrics.pop_front();
        compare_metrics(metric_item, want);
      end
    end
  end

  // result side stall: random gaps plus forced holds
  always @(posedge clk) begin
    metric_stall <= (stall_hold > 0) || (traffic_gaps && $urandom_range(99) < IDLE_PERCENT);
    if (stall_hold > 0) stall_hold--;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t make_pair(sample_t a, sample_t b, logic last);
    in_item_t p;
    p.original_sample      = a;
    p.reconstructed_sample = b;
    p.last_pair            = last;
    return p;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return sample_t'($urandom_range(8)) - sample_t'(4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // mostly a close reconstruction, sometimes an unrelated one
  function automatic in_item_t random_pair(logic last);
    sample_t a;
    sample_t b;
    a = random_sample();
    if ($urandom_range(3) == 0) b = random_sample();
    else b = a + sample_t'($urandom_range(32)) - sample_t'(16);
    return make_pair(a, b, last);
  endfunction

  task automatic send_pair(in_item_t p);
    while (traffic_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    pair_valid <= 1'b1;
    pair_item  <= p;
    do @(posedge clk); while (pair_stall);
    accumulate_pair(p);
  endtask

  // hold the sender until every queued result has transferred
  task automatic drain_results();
    pair_valid <= 1'b0;
    do @(posedge clk); while (expected_metrics.size() != 0);
  endtask

  task automatic test_single_extremes();
    send_pair(make_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    send_pair(make_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1));
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    send_pair(make_pair(sample_t'(0), sample_t'(0), 1'b1));
  endtask

  task automatic test_mixed_measurement();
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_pair(make_pair(sample_t'(0), sample_t'(0), 1'b0));
    send_pair(make_pair(sample_t'(-1), sample_t'(1), 1'b0));
    send_pair(make_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    send_pair(make_pair(sample_t'(1234), sample_t'(-4321), 1'b0));
    send_pair(make_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    // one-sided signals: reconstruction extends the joint range only
    send_pair(make_pair(sample_t'(5), SAMPLE_MAX, 1'b0));
    send_pair(make_pair(sample_t'(7), SAMPLE_MIN, 1'b1));
  endtask

  // results pile up behind a stalled receiver, input must stall too
  task automatic test_result_backpressure();
    traffic_gaps = 1'b0;
    stall_hold   = 40;
    for (int k = 0; k < 6; k++) send_pair(random_pair(1'b1));
    send_pair(random_pair(1'b0));
    send_pair(random_pair(1'b1));
    traffic_gaps = 1'b1;
  endtask

  task automatic test_random_measurements(int unsigned pair_budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < pair_budget) begin
      if ($urandom_range(9) == 0) len = $urandom_range(64, 1);
      else len = $urandom_range(12, 1);
      for (int unsigned k = 1; k <= len; k++) send_pair(random_pair(k == len));
      sent += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_extremes();
    test_mixed_measurement();
    test_result_backpressure();
    drain_results();

    test_random_measurements(300);
    traffic_gaps = 1'b0;
    test_random_measurements(200);
    traffic_gaps = 1'b1;
    drain_results();
    test_random_measurements(300);

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sema_pkg.sv
rtl/core/sema_front.sv
rtl/core/sema_accum.sv
rtl/core/signal_error_metric_accumulator.sv
tb/sv/testbench.sv
